### sv/twn_pkg.sv
// twn_pkg: shared types, byte codes and the removal pattern for the whitespace normalizer
// used by twn_front, twn_fifo, twn_back and the top level; no dependencies
package twn_pkg;

  // byte codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_C2    = 8'hC2;
  localparam logic [7:0] CH_A0    = 8'hA0;
  localparam logic [7:0] CH_E2    = 8'hE2;
  localparam logic [7:0] CH_80    = 8'h80;
  localparam logic [7:0] CH_A8    = 8'hA8;
  localparam logic [7:0] CH_A9    = 8'hA9;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // "_x000D_" is seven bytes; the last one completes the match and is never held
  localparam logic [2:0] KILL_LAST = 3'd6;

  // default depth of the token queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // token from the removal stage to the space-mapping stage
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;  // end of string, no byte
    logic       tail;    // produced while handling the final input byte
  } tok_t;

  // held bytes of a partial space-map match
  typedef enum logic [1:0] {
    S2_IDLE,
    S2_ONE,
    S2_TWO
  } s2_state_t;

  function automatic logic [7:0] kill_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h5F;
      3'd1:    b = 8'h78;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h30;
      3'd5:    b = 8'h44;
      3'd6:    b = 8'h5F;
      default: b = 8'h5F;
    endcase
    return b;
  endfunction

endpackage

### sv/twn_front.sv
// twn_front: input side, removes "_x000D_" and hands bytes and end marks on as tokens
// depends on twn_pkg
module twn_front import twn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       tok_valid,
  output tok_t       tok,
  input  logic       tok_ready
);

  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] held_r [0:5];
  logic [7:0] pb_r, pb_nxt;
  logic       pbv_r, pbv_nxt;
  logic       pbl_r, pbl_nxt;
  logic [2:0] fleft_r, fleft_nxt;
  logic [2:0] fidx_r, fidx_nxt;
  logic       endp_r, endp_nxt;
  logic       held_we;
  logic       hit;

  assign hit = (pb_r == kill_byte(cnt_r));

  assign in_tready = (fleft_r == 3'd0) && !endp_r &&
                     (!pbv_r || (!pbl_r && (hit || ((cnt_r == 3'd0) && tok_ready))));

  always_comb begin
    cnt_nxt   = cnt_r;
    pb_nxt    = pb_r;
    pbv_nxt   = pbv_r;
    pbl_nxt   = pbl_r;
    fleft_nxt = fleft_r;
    fidx_nxt  = fidx_r;
    endp_nxt  = endp_r;
    held_we   = 1'b0;
    tok_valid = 1'b0;
    tok.data  = pb_r;
    tok.is_end = 1'b0;
    tok.tail  = (pbv_r && pbl_r) || endp_r;

    if (fleft_r != 3'd0) begin
      // release held partial match, oldest first
      tok_valid = 1'b1;
      tok.data  = held_r[fidx_r];
      if (tok_ready) begin
        fidx_nxt  = fidx_r + 3'd1;
        fleft_nxt = fleft_r - 3'd1;
      end
    end else if (pbv_r) begin
      if (hit) begin
        pbv_nxt = 1'b0;
        if (cnt_r == KILL_LAST) begin
          cnt_nxt = 3'd0;
        end else begin
          held_we = 1'b1;
          cnt_nxt = cnt_r + 3'd1;
        end
        if (pbl_r) begin
          fleft_nxt = (cnt_r == KILL_LAST) ? 3'd0 : cnt_r + 3'd1;
          fidx_nxt  = 3'd0;
          cnt_nxt   = 3'd0;
          endp_nxt  = 1'b1;
        end
      end else if (cnt_r != 3'd0) begin
        // mismatch: flush, then look at this byte again
        fleft_nxt = cnt_r;
        fidx_nxt  = 3'd0;
        cnt_nxt   = 3'd0;
      end else begin
        tok_valid = 1'b1;
        if (tok_ready) begin
          pbv_nxt  = 1'b0;
          endp_nxt = pbl_r;
        end
      end
    end else if (endp_r) begin
      tok_valid  = 1'b1;
      tok.data   = CH_NUL;
      tok.is_end = 1'b1;
      if (tok_ready) begin
        endp_nxt = 1'b0;
      end
    end

    if (in_tvalid && in_tready) begin
      pb_nxt  = in_tdata;
      pbv_nxt = 1'b1;
      pbl_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      pbv_r   <= 1'b0;
      fleft_r <= 3'd0;
      endp_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      pbv_r   <= pbv_nxt;
      fleft_r <= fleft_nxt;
      endp_r  <= endp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pb_r   <= pb_nxt;
    pbl_r  <= pbl_nxt;
    fidx_r <= fidx_nxt;
    if (held_we) begin
      held_r[cnt_r] <= pb_r;
    end
  end

endmodule

### sv/twn_fifo.sv
// twn_fifo: small register queue of tokens between front and back
// depends on twn_pkg
module twn_fifo import twn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  tok_t wr_tok,
  output logic rd_valid,
  input  logic rd_ready,
  output tok_t rd_tok
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_tok   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

endmodule

### sv/twn_back.sv
// twn_back: maps line breaks, tabs and unicode spaces to a space, collapses and trims spaces,
// marks the end of string and drives the output register; depends on twn_pkg
module twn_back import twn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tok_valid,
  output logic       tok_ready,
  input  tok_t       tok,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  s2_state_t  sc_r, sc_nxt, sc_c;
  logic [7:0] h0_r, h0_nxt, h0_c;
  logic [7:0] h1_r, h1_nxt, h1_c;
  logic       pend_r, pend_nxt;
  logic       seen_r, seen_nxt;
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_b_r, hold_b_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_b_r;
  logic       out_bv_r, out_l_r;

  logic       pop_c, push_v, fin;
  logic [7:0] push_b;
  logic       item_v, item_ok, s3_acc;
  logic [7:0] item_b;
  logic       room, out_load;
  logic [7:0] out_b;
  logic       out_bv, out_l;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_b_r;
  assign out_tuser  = out_bv_r;
  assign out_tlast  = out_l_r;

  always_comb begin
    sc_nxt     = sc_r;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    pend_nxt   = pend_r;
    seen_nxt   = seen_r;
    hold_v_nxt = hold_v_r;
    hold_b_nxt = hold_b_r;
    tok_ready  = 1'b0;
    sc_c       = sc_r;
    h0_c       = h0_r;
    h1_c       = h1_r;
    pop_c      = 1'b0;
    push_v     = 1'b0;
    push_b     = CH_NUL;
    fin        = 1'b0;
    room       = !out_v_r || out_tready;
    out_load   = 1'b0;
    out_b      = CH_NUL;
    out_bv     = 1'b0;
    out_l      = 1'b0;

    // space mapping: at most one byte handed on per cycle
    if (tok_valid) begin
      if (!tok.is_end) begin
        case (sc_r)
          S2_IDLE: begin
            pop_c = 1'b1;
            if (tok.data == CH_CR || tok.data == CH_C2 || tok.data == CH_E2) begin
              h0_c = tok.data;
              sc_c = S2_ONE;
            end else if (tok.data == CH_LF || tok.data == CH_TAB) begin
              push_v = 1'b1;
              push_b = CH_SP;
            end else begin
              push_v = 1'b1;
              push_b = tok.data;
            end
          end
          S2_ONE: begin
            if (h0_r == CH_CR) begin
              push_v = 1'b1;
              push_b = CH_SP;
              sc_c   = S2_IDLE;
              pop_c  = (tok.data == CH_LF);
            end else if (h0_r == CH_C2 && tok.data == CH_A0) begin
              push_v = 1'b1;
              push_b = CH_SP;
              sc_c   = S2_IDLE;
              pop_c  = 1'b1;
            end else if (h0_r == CH_E2 && tok.data == CH_80) begin
              h1_c  = tok.data;
              sc_c  = S2_TWO;
              pop_c = 1'b1;
            end else begin
              // pass the held byte, then look at this one again
              push_v = 1'b1;
              push_b = h0_r;
              sc_c   = S2_IDLE;
            end
          end
          S2_TWO: begin
            if (tok.data == CH_A8 || tok.data == CH_A9) begin
              push_v = 1'b1;
              push_b = CH_SP;
              sc_c   = S2_IDLE;
              pop_c  = 1'b1;
            end else begin
              // the second held byte cannot start a match, so it drains as a single
              push_v = 1'b1;
              push_b = h0_r;
              h0_c   = h1_r;
              sc_c   = S2_ONE;
            end
          end
          default: begin
            sc_c = S2_IDLE;
          end
        endcase
      end else begin
        case (sc_r)
          S2_ONE: begin
            push_v = 1'b1;
            push_b = (h0_r == CH_CR) ? CH_SP : h0_r;
            sc_c   = S2_IDLE;
          end
          S2_TWO: begin
            push_v = 1'b1;
            push_b = h0_r;
            h0_c   = h1_r;
            sc_c   = S2_ONE;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
    end

    // space collapsing
    item_v  = 1'b0;
    item_b  = CH_SP;
    item_ok = 1'b0;
    s3_acc  = 1'b1;
    if (push_v) begin
      if (push_b == CH_SP) begin
        if (seen_r) begin
          pend_nxt = 1'b1;
        end
      end else if (pend_r) begin
        // deferred space goes out first, the byte is offered again once the space is taken
        item_v = 1'b1;
        item_b = CH_SP;
        s3_acc = 1'b0;
      end else begin
        item_v = 1'b1;
        item_b = push_b;
        s3_acc = 1'b0;
      end
    end

    // items of the final step wait in the hold register for the last flag
    if (item_v) begin
      if (tok.tail) begin
        if (!hold_v_r) begin
          item_ok    = 1'b1;
          hold_v_nxt = 1'b1;
          hold_b_nxt = item_b;
        end else if (room) begin
          item_ok    = 1'b1;
          out_load   = 1'b1;
          out_b      = hold_b_r;
          out_bv     = 1'b1;
          hold_b_nxt = item_b;
        end
      end else if (room) begin
        item_ok  = 1'b1;
        out_load = 1'b1;
        out_b    = item_b;
        out_bv   = 1'b1;
      end
      if (item_ok) begin
        if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          seen_nxt = 1'b1;
          s3_acc   = 1'b1;
        end
      end
    end

    if (fin) begin
      if (room) begin
        out_load   = 1'b1;
        out_b      = hold_v_r ? hold_b_r : CH_NUL;
        out_bv     = hold_v_r;
        out_l      = 1'b1;
        hold_v_nxt = 1'b0;
        pend_nxt   = 1'b0;
        seen_nxt   = 1'b0;
        tok_ready  = 1'b1;
      end
    end else if (tok_valid && s3_acc) begin
      sc_nxt    = sc_c;
      h0_nxt    = h0_c;
      h1_nxt    = h1_c;
      tok_ready = pop_c;
    end

    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r     <= S2_IDLE;
      pend_r   <= 1'b0;
      seen_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      sc_r     <= sc_nxt;
      pend_r   <= pend_nxt;
      seen_r   <= seen_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r     <= h0_nxt;
    h1_r     <= h1_nxt;
    hold_b_r <= hold_b_nxt;
    if (out_load) begin
      out_b_r  <= out_b;
      out_bv_r <= out_bv;
      out_l_r  <= out_l;
    end
  end

endmodule

### sv/text_whitespace_normalizer.sv
// text_whitespace_normalizer: top level, front stage, token queue and back stage
// depends on twn_pkg, twn_front, twn_fifo, twn_back
// path: a byte passes the front's byte register, the token queue and the output register
// throughput: one byte per cycle between stalls; the input stalls while a broken "_x000D_"
//   match drains, and after a string's last byte until held tag bytes and the end mark drain;
//   the back re-offers a token per held byte it releases, per deferred space, per lone CR
// reset: synchronous, active low; clears all match counts, queue and output valid
module text_whitespace_normalizer import twn_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // tokens between front and back, 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // final byte of the string
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] byte_valid, low on a bare end marker
  output logic       out_tlast   // final item of the string
);

  // front to queue
  logic f_valid, f_ready;
  tok_t f_tok;
  // queue to back
  logic q_valid, q_ready;
  tok_t q_tok;

  // removal of "_x000D_", one token per cycle while the queue has room
  twn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .tok_valid (f_valid),
    .tok       (f_tok),
    .tok_ready (f_ready)
  );

  // decouples front stalls from back stalls
  twn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_tok   (f_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_tok   (q_tok)
  );

  // space mapping, collapse and trim, output register
  twn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (q_valid),
    .tok_ready  (q_ready),
    .tok        (q_tok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/twn_checker.sv
// twn_checker: port-level checks of the normalized output stream, bound to the top level
// depends on text_whitespace_normalizer
module twn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  logic prev_sp_r;   // last transferred item was a space
  logic sos_r;       // next item starts a string

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sp_r <= 1'b0;
      sos_r     <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      prev_sp_r <= out_tuser && (out_tdata == 8'h20);
      sos_r     <= out_tlast;
    end
  end

  // a bare end marker is always the last item and carries zero
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("bare end marker without last or with nonzero byte");

  // runs of spaces are collapsed
  a_no_double_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && (out_tdata == 8'h20) |-> !prev_sp_r)
    else $error("two spaces in a row");

  // leading space trimmed
  a_no_lead_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && (out_tdata == 8'h20) |-> !sos_r)
    else $error("string starts with a space");

  // trailing space trimmed
  a_no_trail_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> (out_tdata != 8'h20))
    else $error("string ends with a space");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind text_whitespace_normalizer twn_checker u_twn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
